// ----- sv/gkg_pkg.sv -----
// Shared types and constants for the Gaussian kernel generator.
// No dependencies; used by gkg_div and gaussian_kernel_generator.
package gkg_pkg;

	localparam int QUOT_W = 21;
	localparam int NUM_W  = 52;

	localparam logic [15:0] SIGMA_MIN = 16'd2048;
	localparam logic [31:0] LOG2E_Q16 = 32'd94548;
	localparam logic [31:0] LN2_Q30   = 32'd744261118;
	localparam logic [31:0] EHALF_Q16 = 32'd39750;
	localparam logic [3:0]  TAYLOR_TERMS = 4'd12;
	localparam logic [4:0]  X_QBITS    = 5'd20;
	localparam logic [4:0]  COEF_QBITS = 5'd16;

	typedef struct packed {
		logic              start;
		logic [NUM_W-1:0]  num;
		logic [31:0]       den;
		logic [4:0]        qbits;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quot;
	} div_rsp_t;

	// floor((2^32-1)/k): reciprocal for the Taylor term divide, exact after one correction
	function automatic logic [31:0] recip(input logic [3:0] k);
		logic [31:0] r;
		case (k)
			4'd1:    r = 32'd4294967295;
			4'd2:    r = 32'd2147483647;
			4'd3:    r = 32'd1431655765;
			4'd4:    r = 32'd1073741823;
			4'd5:    r = 32'd858993459;
			4'd6:    r = 32'd715827882;
			4'd7:    r = 32'd613566756;
			4'd8:    r = 32'd536870911;
			4'd9:    r = 32'd477218588;
			4'd10:   r = 32'd429496729;
			4'd11:   r = 32'd390451572;
			4'd12:   r = 32'd357913941;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

// ----- sv/gkg_mul.sv -----
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on nothing; instantiated by gaussian_kernel_generator.
module gkg_mul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] p
);

	logic [63:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= 64'(a) * 64'(b);
	end

	assign p = p_q;

endmodule

// ----- sv/gkg_div.sv -----
// Restoring divider, one quotient bit per cycle, qbits+1 bits in all.
// The top quotient bit flags a quotient of 2^qbits or more. Uses gkg_pkg.
module gkg_div (
	input  logic              clk,
	input  logic              arst_n,
	input  gkg_pkg::div_req_t req,
	output gkg_pkg::div_rsp_t rsp
);

	logic [gkg_pkg::NUM_W-1:0]  rem_q;
	logic [gkg_pkg::NUM_W-1:0]  dsh_q;
	logic [gkg_pkg::QUOT_W-1:0] quo_q;
	logic [4:0]                 cnt_q;
	logic                       run_q;
	logic                       done_q;
	logic                       ge;

	assign ge = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 5'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= req.qbits;
			end else if (run_q) begin
				if (cnt_q == 5'd0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			dsh_q <= {20'd0, req.den} << req.qbits;
			quo_q <= '0;
		end else if (run_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[gkg_pkg::QUOT_W-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule

// ----- sv/gaussian_kernel_generator.sv -----
// Top level of the Gaussian / Gaussian-derivative kernel generator.
// Depends on gkg_pkg, gkg_mul and gkg_div.
//
// One item (sigma in Q4.12, clamped up to 0.5, and the kernel choice in
// s_tuser) produces one kernel of kernel_width taps, sent one tap per output
// item with m_tlast on the final tap. Every sample exp(-i^2/2sigma^2) over the
// full span of 2*(MAX_TAPS/2)+1 positions is worked out on one shared
// multiplier and one shared restoring divider: per sample one 21-step
// divide for i^2/sigma^2, two multiplies for the exp2 split and a Taylor
// series through the twelfth power (the multiplies and the series are
// skipped when the sample underflows to zero). Equal tails are then trimmed,
// a sweep over the kept taps builds the normalising sum, and each tap is
// divided by it on the same divider (a zero sum gives a zero tap instead)
// before it is offered. The block takes no new item until the last tap of
// the current kernel has been taken. width_too_small is set when either the
// Gaussian or its derivative kept the whole span.
module gaussian_kernel_generator #(
	parameter int MAX_TAPS = 63
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [15:0] sigma
	input  logic        s_tuser,  // [0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [5:0] tap_index, [21:6] coefficient,
	                              // [27:22] kernel_width, [28] width_too_small
	output logic        m_tlast   // last
);

	localparam int HALF = MAX_TAPS / 2;
	localparam int SPAN = 2 * HALF + 1;
	localparam int AW   = $clog2(SPAN);

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_SQ   = 5'd1;
	localparam logic [4:0] ST_PK   = 5'd2;
	localparam logic [4:0] ST_PKL  = 5'd3;
	localparam logic [4:0] ST_DX   = 5'd4;
	localparam logic [4:0] ST_DW   = 5'd5;
	localparam logic [4:0] ST_Y    = 5'd6;
	localparam logic [4:0] ST_T    = 5'd7;
	localparam logic [4:0] ST_TM   = 5'd8;
	localparam logic [4:0] ST_TD   = 5'd9;
	localparam logic [4:0] ST_TF   = 5'd10;
	localparam logic [4:0] ST_G    = 5'd11;
	localparam logic [4:0] ST_TAP  = 5'd12;
	localparam logic [4:0] ST_DI   = 5'd13;
	localparam logic [4:0] ST_DA   = 5'd14;
	localparam logic [4:0] ST_DC   = 5'd15;
	localparam logic [4:0] ST_OR   = 5'd16;
	localparam logic [4:0] ST_OD   = 5'd17;
	localparam logic [4:0] ST_OW   = 5'd18;
	localparam logic [4:0] ST_OS   = 5'd19;

	logic [4:0]  state_q;

	// item and per-item constants
	logic [15:0] sig_q;
	logic        deriv_q;
	logic [31:0] sigsq_q;
	logic [21:0] peak_q;

	// sampling pass
	logic [5:0]  k_q;
	logic [4:0]  n_q;
	logic [29:0] t_q;
	logic [30:0] term_q;
	logic signed [32:0] sum_q;
	logic [3:0]  kk_q;
	logic [29:0] v_q;
	logic [18:0] g_q;
	logic [5:0]  cg_q;
	logic [5:0]  cd_q;
	logic        gact_q;
	logic        dact_q;

	// trimming, normalising and output
	logic [5:0]  trim_count_q;
	logic [5:0]  width_q;
	logic        tsmall_q;
	logic [31:0] norm_sum_q;
	logic [5:0]  rk_q;
	logic [5:0]  oi_q;
	logic        neg_q;

	logic        m_tvalid_q;
	logic [5:0]  o_idx_q;
	logic [15:0] o_coef_q;
	logic        o_last_q;

	// tap store
	logic [23:0] tap_store [SPAN];
	logic [23:0] rdata_q;
	logic [AW-1:0] raddr;

	// shared units
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;
	gkg_pkg::div_req_t div_req;
	gkg_pkg::div_rsp_t div_rsp;

	gkg_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	gkg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// sample position relative to the centre
	logic signed [6:0]  tap_i;
	logic [4:0]         i_abs;
	logic [9:0]         i_sq;
	logic signed [26:0] gi_prod;
	logic [23:0]        d_val;
	logic [23:0]        d_mag;
	logic [25:0]        g100;
	logic [30:0]        d100;

	assign tap_i   = $signed({1'b0, k_q}) - $signed(7'(HALF));
	assign i_abs   = tap_i[6] ? 5'(-tap_i) : tap_i[4:0];
	assign i_sq    = 10'(i_abs) * 10'(i_abs);
	assign gi_prod = 27'(tap_i) * $signed({8'd0, g_q});
	assign d_val   = 24'(-gi_prod);
	assign d_mag   = 24'(i_abs) * 24'(g_q);
	assign g100    = 26'(g_q) * 26'd100;
	assign d100    = 31'(d_mag) * 31'd100;

	// Taylor term divide correction
	logic [29:0] q0;
	logic [29:0] q0k;
	logic [29:0] rem_k;
	logic        corr;
	logic [30:0] term_new;

	assign q0       = mul_p[61:32];
	assign q0k      = 30'(34'(q0) * 34'(kk_q));
	assign rem_k    = v_q - q0k;
	assign corr     = rem_k >= 30'(kk_q);
	assign term_new = 31'(q0) + 31'(corr);

	// rounding shift to Q18
	logic [5:0]  gsh;
	logic [39:0] grnd;
	logic [39:0] gsum;

	assign gsh  = 6'(n_q) + 6'd12;
	assign grnd = 40'd1 << (gsh - 6'd1);
	assign gsum = (40'(sum_q) + grnd) >> gsh;

	// normalising sum term
	logic signed [6:0]  den_i;
	logic signed [30:0] den_prod;
	logic [31:0]        den_add;

	assign den_i    = $signed({1'b0, rk_q}) - $signed(7'(HALF));
	assign den_prod = 31'(den_i) * 31'($signed(rdata_q));
	assign den_add  = deriv_q ? 32'(-den_prod) : {{8{rdata_q[23]}}, rdata_q};

	// coefficient rounding and saturation
	logic [23:0] tap_mag;
	logic [15:0] cmag;
	logic [16:0] cmag_sat;
	logic [15:0] coef;

	assign tap_mag  = rdata_q[23] ? 24'(-rdata_q) : rdata_q;
	assign cmag     = div_rsp.quot[15:0];
	assign cmag_sat = (div_rsp.quot[16] || cmag > 16'd32768) ? 17'd32768 : 17'(cmag);
	assign coef     = neg_q ? 16'(-cmag_sat)
	                        : ((cmag_sat > 17'd32767) ? 16'd32767 : cmag_sat[15:0]);

	logic [5:0] trim_sel;
	assign trim_sel = deriv_q ? cd_q : cg_q;

	// operand selection for the shared units
	always_comb begin
		mul_a = 32'd0;
		mul_b = 32'd0;
		case (state_q)
			ST_SQ: begin
				mul_a = 32'(sig_q);
				mul_b = 32'(sig_q);
			end
			ST_PK: begin
				mul_a = 32'(sig_q);
				mul_b = gkg_pkg::EHALF_Q16;
			end
			ST_DW: begin
				mul_a = 32'(div_rsp.quot[19:0]);
				mul_b = gkg_pkg::LOG2E_Q16;
			end
			ST_Y: begin
				mul_a = 32'(mul_p[31:16]);
				mul_b = gkg_pkg::LN2_Q30;
			end
			ST_TM: begin
				mul_a = 32'(term_q);
				mul_b = 32'(t_q);
			end
			ST_TD: begin
				mul_a = 32'(mul_p[59:30]);
				mul_b = gkg_pkg::recip(kk_q);
			end
			default: begin
				mul_a = 32'd0;
				mul_b = 32'd0;
			end
		endcase
	end

	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = {3'd0, i_sq, 39'd0};
		div_req.den   = sigsq_q;
		div_req.qbits = gkg_pkg::X_QBITS;
		if (state_q == ST_DX) begin
			div_req.start = 1'b1;
		end else if (state_q == ST_OD) begin
			div_req.start = norm_sum_q != 32'd0;
			div_req.num   = {13'd0, tap_mag, 15'd0} + {21'd0, norm_sum_q[31:1]};
			div_req.den   = norm_sum_q;
			div_req.qbits = gkg_pkg::COEF_QBITS;
		end
	end

	always_comb begin
		if (state_q == ST_OR) begin
			raddr = AW'(oi_q + trim_count_q);
		end else begin
			raddr = rk_q[AW-1:0];
		end
	end

	// tap store: written during sampling, read during the sum and output passes
	always_ff @(posedge clk) begin
		if (state_q == ST_TAP) begin
			tap_store[k_q[AW-1:0]] <= deriv_q ? d_val : {5'd0, g_q};
		end
		rdata_q <= tap_store[raddr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			m_tvalid_q   <= 1'b0;
			k_q          <= 6'd0;
			kk_q         <= 4'd0;
			rk_q         <= 6'd0;
			oi_q         <= 6'd0;
			cg_q         <= 6'd0;
			cd_q         <= 6'd0;
			gact_q       <= 1'b0;
			dact_q       <= 1'b0;
			trim_count_q <= 6'd0;
			norm_sum_q   <= 32'd0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					state_q <= ST_PK;
				end
				ST_PK: begin
					state_q <= ST_PKL;
				end
				ST_PKL: begin
					k_q     <= 6'd0;
					cg_q    <= 6'd0;
					cd_q    <= 6'd0;
					gact_q  <= 1'b1;
					dact_q  <= 1'b1;
					state_q <= ST_DX;
				end
				ST_DX: begin
					state_q <= ST_DW;
				end
				ST_DW: begin
					// past sixteen the sample underflows to zero
					if (div_rsp.done) begin
						state_q <= div_rsp.quot[20] ? ST_TAP : ST_Y;
					end
				end
				ST_Y: begin
					state_q <= ST_T;
				end
				ST_T: begin
					kk_q    <= 4'd1;
					state_q <= ST_TM;
				end
				ST_TM: begin
					state_q <= ST_TD;
				end
				ST_TD: begin
					state_q <= ST_TF;
				end
				ST_TF: begin
					if (kk_q == gkg_pkg::TAYLOR_TERMS) begin
						state_q <= ST_G;
					end else begin
						kk_q    <= kk_q + 4'd1;
						state_q <= ST_TM;
					end
				end
				ST_G: begin
					state_q <= ST_TAP;
				end
				ST_TAP: begin
					// trim counts advance only over the left half, while still below
					if (k_q < 6'(HALF)) begin
						if (gact_q && g100 < 26'd262144) begin
							cg_q <= cg_q + 6'd1;
						end else begin
							gact_q <= 1'b0;
						end
						if (dact_q && d100 < 31'(peak_q)) begin
							cd_q <= cd_q + 6'd1;
						end else begin
							dact_q <= 1'b0;
						end
					end
					if (k_q == 6'(SPAN - 1)) begin
						state_q <= ST_DI;
					end else begin
						k_q     <= k_q + 6'd1;
						state_q <= ST_DX;
					end
				end
				ST_DI: begin
					trim_count_q <= trim_sel;
					rk_q         <= trim_sel;
					norm_sum_q   <= 32'd0;
					state_q      <= ST_DA;
				end
				ST_DA: begin
					state_q <= ST_DC;
				end
				ST_DC: begin
					norm_sum_q <= norm_sum_q + den_add;
					if (rk_q == 6'(SPAN - 1) - trim_count_q) begin
						oi_q    <= 6'd0;
						state_q <= ST_OR;
					end else begin
						rk_q    <= rk_q + 6'd1;
						state_q <= ST_DA;
					end
				end
				ST_OR: begin
					state_q <= ST_OD;
				end
				ST_OD: begin
					// a zero sum gives all-zero coefficients
					if (norm_sum_q == 32'd0) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_OS;
					end else begin
						state_q <= ST_OW;
					end
				end
				ST_OW: begin
					if (div_rsp.done) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_OS;
					end
				end
				ST_OS: begin
					if (m_tready) begin
						m_tvalid_q <= 1'b0;
						if (oi_q == width_q - 6'd1) begin
							state_q <= ST_IDLE;
						end else begin
							oi_q    <= oi_q + 6'd1;
							state_q <= ST_OR;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				sig_q   <= (s_tdata < gkg_pkg::SIGMA_MIN) ? gkg_pkg::SIGMA_MIN : s_tdata;
				deriv_q <= s_tuser;
			end
			ST_PK: begin
				sigsq_q <= mul_p[31:0];
			end
			ST_PKL: begin
				peak_q <= mul_p[31:10];
			end
			ST_DW: begin
				g_q <= 19'd0;
			end
			ST_Y: begin
				n_q <= mul_p[36:32];
			end
			ST_T: begin
				t_q    <= mul_p[45:16];
				term_q <= 31'h4000_0000;
				sum_q  <= 33'sh0_4000_0000;
			end
			ST_TD: begin
				v_q <= mul_p[59:30];
			end
			ST_TF: begin
				term_q <= term_new;
				if (kk_q[0]) begin
					sum_q <= sum_q - $signed({2'b00, term_new});
				end else begin
					sum_q <= sum_q + $signed({2'b00, term_new});
				end
			end
			ST_G: begin
				g_q <= gsum[18:0];
			end
			ST_DI: begin
				width_q  <= 6'(SPAN) - {trim_sel[4:0], 1'b0};
				tsmall_q <= (cg_q == 6'd0) || (cd_q == 6'd0);
			end
			ST_OD: begin
				neg_q    <= rdata_q[23];
				o_idx_q  <= oi_q;
				o_coef_q <= 16'd0;
				o_last_q <= oi_q == width_q - 6'd1;
			end
			ST_OW: begin
				o_coef_q <= coef;
			end
			default: begin
			end
		endcase
	end

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = o_last_q;
	assign m_tdata  = {3'd0, tsmall_q, width_q, o_coef_q, o_idx_q};

	// a kernel is never offered while a new item can be taken
	a_idle_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid)
		else $error("output pending while idle");

	// the tap index stays inside the kernel, and the final tap closes it
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (o_idx_q < width_q))
		else $error("tap index beyond kernel width");

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (o_idx_q == width_q - 6'd1))
		else $error("last tap not at end of kernel");

	// trimming is symmetric, so the width is odd
	a_width_odd: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> width_q[0])
		else $error("even kernel width");

	// the divider only finishes while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DW || state_q == ST_OW))
		else $error("divider result with nobody waiting");

endmodule

// ----- dv/gaussian_kernel_generator_test.sv -----
// Self-checking bench for gaussian_kernel_generator: drives sigma and kernel
// choice, predicts every kernel tap in fixed point and checks each output item.
// Depends on gkg_pkg and the gaussian_kernel_generator RTL.
module gaussian_kernel_generator_test;

	localparam int MAX_TAPS  = 63;
	localparam int HALF      = MAX_TAPS / 2;
	localparam int SPAN      = 2 * HALF + 1;
	localparam int OP_GAUSS  = 0;
	localparam int OP_DERIV  = 1;
	localparam int WDOG_MAX  = 200000;

	typedef struct packed {
		logic [15:0] sigma;
		logic        opcode;
	} kernel_req_t;

	typedef struct packed {
		logic [5:0]  tap_index;
		logic [15:0] coefficient;
		logic [5:0]  kernel_width;
		logic        width_too_small;
		logic        last;
	} tap_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tlast;

	kernel_req_t req_queue[$];
	tap_t        tap_queue[$];
	int          mismatches;
	int          idle_cycles;
	int          hold_off;
	int          wait_in;
	int          wait_out;

	// handshake seen at the rising edge, used by the driver on the next fall
	logic s_tready_q;

	gaussian_kernel_generator #(.MAX_TAPS(MAX_TAPS)) DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// exp(-i^2/2sigma^2) in Q18, via exp2 split and a truncated Taylor series
	function automatic longint sample_q18(input longint i, input longint sig);
		longint unsigned x, y, n, f;
		longint t, term, acc;
		x = (longint'(i * i) << 39) / (sig * sig);
		if (x >= (64'd16 << 16))
			return 0;
		y = (x * 94548) >> 16;
		n = y >> 16;
		f = y & 16'hFFFF;
		t = longint'((f * 744261118) >> 16);
		term = longint'(1) << 30;
		acc = term;
		for (int k = 1; k <= 12; k++) begin
			term = ((term * t) >>> 30) / k;
			if (k % 2)
				acc -= term;
			else
				acc += term;
		end
		return (acc + (longint'(1) << (11 + n))) >>> (12 + n);
	endfunction

	function automatic int tails_below(input longint v[SPAN], input longint peak,
			input bit deriv);
		int c;
		longint m;
		c = 0;
		while (c < HALF) begin
			m = v[c] < 0 ? -v[c] : v[c];
			if (deriv ? (100 * m >= peak) : (100 * m >= 262144))
				break;
			c++;
		end
		return c;
	endfunction

	function automatic logic [15:0] to_q15(input longint num, input longint unsigned den);
		longint unsigned mag;
		longint r;
		if (den == 0)
			return 16'd0;
		mag = num < 0 ? -num : num;
		mag = (mag * 32768 + den / 2) / den;
		if (mag > 32768)
			mag = 32768;
		r = num < 0 ? -longint'(mag) : longint'(mag);
		if (r > 32767)
			r = 32767;
		return r[15:0];
	endfunction

	// Build the whole trimmed kernel for one request and queue its taps
	task automatic predict_kernel(input kernel_req_t rq);
		longint          g[SPAN];
		longint          d[SPAN];
		longint          sig, peak, v, pos;
		longint unsigned den;
		int              cg, cd, c, w;
		bit              narrow;
		tap_t            tp;
		sig = rq.sigma < 16'd2048 ? 2048 : rq.sigma;
		for (int k = 0; k < SPAN; k++) begin
			pos = k - HALF;
			g[k] = sample_q18(pos, sig);
			d[k] = -pos * g[k];
		end
		peak = (sig * 39750) >> 10;
		cg = tails_below(g, peak, 1'b0);
		cd = tails_below(d, peak, 1'b1);
		narrow = (cg == 0) || (cd == 0);
		c = rq.opcode == OP_DERIV ? cd : cg;
		w = SPAN - 2 * c;
		den = 0;
		for (int k = 0; k < w; k++) begin
			v = rq.opcode == OP_DERIV ? d[k + c] : g[k + c];
			den += rq.opcode == OP_DERIV ? longint'(-(k - w / 2) * v) : v;
		end
		den = den & 64'hFFFF_FFFF;
		for (int k = 0; k < w; k++) begin
			v = rq.opcode == OP_DERIV ? d[k + c] : g[k + c];
			v = longint'(signed'(v[23:0]));
			tp.tap_index       = k[5:0];
			tp.coefficient     = to_q15(v, den);
			tp.kernel_width    = w[5:0];
			tp.width_too_small = narrow;
			tp.last            = (k == w - 1);
			tap_queue.push_back(tp);
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		mismatches++;
	endtask

	// Driver: present the oldest pending item after a random gap
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			wait_in  <= 0;
		end else begin
			if (s_tvalid && s_tready_q) begin
				if (req_queue.size() > 0)
					void'(req_queue.pop_front());
			end
			if (s_tvalid && !s_tready_q) begin
				// hold the item until taken
			end else if (wait_in > 0) begin
				s_tvalid <= 1'b0;
				wait_in  <= wait_in - 1;
			end else if (req_queue.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tdata  <= req_queue[0].sigma;
				s_tuser  <= req_queue[0].opcode;
				wait_in  <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s_tready_q <= 1'b0;
		else
			s_tready_q <= s_tvalid && s_tready;
	end

	// Receiver back-pressure; one long hold-off is counted here
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			wait_out <= 0;
		end else if (hold_off > 0) begin
			m_tready <= 1'b0;
			hold_off <= hold_off - 1;
		end else if (m_tvalid && m_tready) begin
			wait_out <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
			m_tready <= 1'b0;
		end else if (wait_out > 0) begin
			m_tready <= 1'b0;
			wait_out <= wait_out - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Monitor: predict on input acceptance, check each accepted tap
	always @(posedge clk) begin
		tap_t got, want;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (s_tvalid && s_tready) begin
				predict_kernel('{sigma: s_tdata, opcode: s_tuser});
			end
			if (m_tvalid && m_tready) begin
				got = {m_tdata[5:0], m_tdata[21:6], m_tdata[27:22], m_tdata[28], m_tlast};
				if (tap_queue.size() == 0) begin
					report_mismatch("unexpected tap", m_tdata[5:0], -1);
				end else begin
					want = tap_queue.pop_front();
					if (got.tap_index != want.tap_index)
						report_mismatch("tap_index", got.tap_index, want.tap_index);
					if (got.coefficient != want.coefficient)
						report_mismatch("coefficient", $signed(got.coefficient),
							$signed(want.coefficient));
					if (got.kernel_width != want.kernel_width)
						report_mismatch("kernel_width", got.kernel_width,
							want.kernel_width);
					if (got.width_too_small != want.width_too_small)
						report_mismatch("width_too_small", got.width_too_small,
							want.width_too_small);
					if (got.last != want.last)
						report_mismatch("last", got.last, want.last);
				end
			end
			if (idle_cycles >= WDOG_MAX) begin
				$display("watchdog expired");
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	task automatic push_req(input int sig, input int op);
		kernel_req_t rq;
		rq.sigma  = sig[15:0];
		rq.opcode = op[0];
		req_queue.push_back(rq);
	endtask

	initial begin
		int sig;
		mismatches  = 0;
		idle_cycles = 0;
		hold_off    = 0;
		arst_n      = 1'b0;
		s_tdata     = 16'd0;
		s_tuser     = 1'b0;
		// directed: clamped sigmas, the minimum, the extremes and both kernels
		push_req(0, OP_GAUSS);      push_req(0, OP_DERIV);
		push_req(1, OP_GAUSS);      push_req(2047, OP_DERIV);
		push_req(2048, OP_GAUSS);   push_req(2048, OP_DERIV);
		push_req(2049, OP_GAUSS);   push_req(4096, OP_DERIV);
		push_req(65535, OP_GAUSS);  push_req(65535, OP_DERIV);
		push_req(43690, OP_GAUSS);  push_req(21845, OP_DERIV);
		push_req(32768, OP_GAUSS);  push_req(12000, OP_DERIV);
		push_req(16'hFFFE, OP_DERIV); push_req(16'h0FFF, OP_GAUSS);
		// random: mostly valid sigmas, some below minimum to exercise the clamp
		for (int n = 0; n < 450; n++) begin
			case ($urandom_range(0, 9))
				0:       sig = $urandom_range(0, 2047);
				1, 2:    sig = $urandom_range(2048, 8191);
				default: sig = $urandom_range(0, 65535);
			endcase
			push_req(sig, $urandom_range(0, 1));
		end
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		// long receiver hold-off while items keep being offered
		repeat (20) @(posedge clk);
		hold_off = 400;
		wait (req_queue.size() == 0 && !s_tvalid);
		wait (tap_queue.size() == 0);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && tap_queue.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/gkg_pkg.sv
sv/gkg_mul.sv
sv/gkg_div.sv
sv/gaussian_kernel_generator.sv
dv/gaussian_kernel_generator_test.sv
